### rtl/core/wfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait-for graph package
// Shared operation codes, widths and defaults for the deadlock detector.
// ----------------------------------------------------------------------------
package wfg_pkg;

    localparam int NODES_DEF = 16;
    localparam int OP_W      = 3;
    localparam int ID_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_RMNODE = 3'd2,
        OP_DETECT = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

endpackage

### rtl/core/wait_for_graph_deadlock_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait-for graph deadlock detector
// Adjacency matrix in a row memory with a depth-first cycle search.
// ----------------------------------------------------------------------------
// Channel   Signals                              Handshake
// command   operation, waiter, holder            start & !busy
// result    deadlock_found                       done strobe, one cycle
//
// Add and remove keep busy high through S_EDRD and S_EDWR (row read, modify and write).
// Remove-node and clear sweep all rows one at a time, each read and then written back.
// Detect scans each start node, tests the adjacency bits of each visited node
// one by one, pops finished levels and reloads each parent from the stack.
// Unknown operations and out-of-range edits are accepted and leave busy low.
// Reset runs a clearing pass over all rows with busy high.
// The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module wait_for_graph_deadlock_detector_core
    import wfg_pkg::*;
#(
    parameter int NODES = NODES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [OP_W-1:0] operation,
    input  logic [ID_W-1:0] waiter,
    input  logic [ID_W-1:0] holder,
    output logic            done,
    output logic            deadlock_found
);

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = AW + 1;
    localparam int SW = AW + CW;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_EDRD  = 9'b000000100,
        S_EDWR  = 9'b000001000,
        S_SWEEP = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_POP   = 9'b001000000,
        S_STEP  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Row memory and search stack (node and cursor of each saved level).
    logic [NODES-1:0] adj_mem [NODES];
    logic [SW-1:0]    stk_mem [NODES];

    logic [NODES-1:0] rd_data;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    wr_addr;
    logic [NODES-1:0] wr_data;

    logic [OP_W-1:0]  op_reg;
    logic [AW-1:0]    wa_reg, ho_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NODES-1:0] vis_reg, vis_next, path_reg, path_next;
    logic [CW-1:0]    dep_reg, dep_next;
    logic [AW-1:0]    node_reg, node_next;
    logic [CW-1:0]    c_reg, c_next;
    logic             found_reg, found_next;
    logic             done_next;

    logic             stk_we;
    logic [AW-1:0]    stk_wa;
    logic [SW-1:0]    stk_wd;
    logic [AW-1:0]    stk_ra;
    logic [SW-1:0]    stk_rd;
    logic [AW-1:0]    top_idx;
    logic             in_range;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        rd_data <= adj_mem[rd_addr];
    end

    // The stack holds every level below the top; the top lives in registers.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_rd <= stk_mem[stk_ra];
    end

    assign in_range = (32'(waiter) < NODES) && (32'(holder) < NODES);
    assign top_idx  = AW'(dep_reg - CW'(1));
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vis_next   = vis_reg;
        path_next  = path_reg;
        dep_next   = dep_reg;
        node_next  = node_reg;
        c_next     = c_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        rd_addr    = wa_reg;
        we         = 1'b0;
        wr_addr    = AW'(cnt_reg);
        wr_data    = '0;
        stk_we     = 1'b0;
        stk_wa     = top_idx;
        stk_wd     = {node_reg, c_reg + CW'(1)};
        stk_ra     = AW'(dep_reg - CW'(2));
        case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = AW'(waiter);
                if (start)
                begin
                    cnt_next = '0;
                    c_next   = '0;
                    case (operation)
                        OP_ADD, OP_REMOVE:
                            if (in_range) state_next = S_EDRD;
                        OP_RMNODE:
                            if (32'(waiter) < NODES) state_next = S_SWEEP;
                        OP_CLEAR:
                            state_next = S_SWEEP;
                        OP_DETECT:
                        begin
                            vis_next   = '0;
                            path_next  = '0;
                            dep_next   = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_EDRD:
            begin
                // Row read issued last cycle; data valid now.
                state_next = S_EDWR;
            end
            S_EDWR:
            begin
                we      = 1'b1;
                wr_addr = wa_reg;
                wr_data = rd_data;
                wr_data[ho_reg] = (op_reg == OP_ADD);
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                // Read-modify-write over all rows, one row at a time: read it, then write it back.
                rd_addr = AW'(cnt_reg);
                if (c_reg[0])
                begin
                    we      = 1'b1;
                    wr_data = rd_data;
                    wr_data[wa_reg] = 1'b0;
                    if (op_reg == OP_CLEAR || AW'(cnt_reg) == wa_reg)
                    begin
                        wr_data = '0;
                    end
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NODES - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
                c_next = {{(CW-1){1'b0}}, ~c_reg[0]};
            end
            S_SCAN:
            begin
                // Pick the next start candidate; cnt holds its index.
                if (cnt_reg == CW'(NODES))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    rd_addr    = AW'(cnt_reg);
                    node_next  = AW'(cnt_reg);
                    c_next     = '0;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_STEP;
                end
            end
            S_POP:
            begin
                // Reload the parent level and its row.
                node_next  = stk_rd[SW-1:CW];
                c_next     = stk_rd[CW-1:0];
                rd_addr    = stk_rd[SW-1:CW];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // The row of the top node is on rd_data; keep it there.
                rd_addr = node_reg;
                if (dep_reg == '0)
                begin
                    // Start a tree only from an unvisited node with edges.
                    if (rd_data != '0 && !vis_reg[node_reg])
                    begin
                        vis_next[node_reg]  = 1'b1;
                        path_next[node_reg] = 1'b1;
                        dep_next = CW'(1);
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (c_reg == CW'(NODES))
                begin
                    // All neighbors tried: leave the path and pop.
                    path_next[node_reg] = 1'b0;
                    dep_next = dep_reg - CW'(1);
                    if (dep_reg == CW'(1))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
                else
                begin
                    c_next = c_reg + CW'(1);
                    if (rd_data[AW'(c_reg)])
                    begin
                        if (path_reg[AW'(c_reg)])
                        begin
                            found_next = 1'b1;
                            dep_next   = '0;
                            state_next = S_OUT;
                        end
                        else if (!vis_reg[AW'(c_reg)] && dep_reg < CW'(NODES))
                        begin
                            // Save the current level and descend into the neighbor.
                            stk_we = 1'b1;
                            vis_next[AW'(c_reg)]  = 1'b1;
                            path_next[AW'(c_reg)] = 1'b1;
                            node_next = AW'(c_reg);
                            c_next    = '0;
                            dep_next  = dep_reg + CW'(1);
                            rd_addr   = AW'(c_reg);
                        end
                    end
                end
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            c_reg     <= '0;
            dep_reg   <= '0;
            done      <= 1'b0;
            vis_reg   <= '0;
            path_reg  <= '0;
            node_reg  <= '0;
            found_reg <= 1'b0;
            op_reg    <= '0;
            wa_reg    <= '0;
            ho_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            c_reg     <= c_next;
            dep_reg   <= dep_next;
            done      <= done_next;
            vis_reg   <= vis_next;
            path_reg  <= path_next;
            node_reg  <= node_next;
            found_reg <= found_next;
            if (state_reg == S_IDLE && start)
            begin
                op_reg <= operation;
                wa_reg <= AW'(waiter);
                ho_reg <= AW'(holder);
            end
        end
    end

    assign deadlock_found = found_reg;

    // A result strobe follows only the output state.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_OUT))
        else $error("done without output state");

    // No item is accepted while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> busy)
        else $error("busy low during clearing pass");

    // The block is ready again while a result is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy during result strobe");

    // The search never goes deeper than the node count.
    assert property (@(posedge clk) disable iff (!rst_n)
        dep_reg <= CW'(NODES))
        else $error("search depth overflow");

    // Stack writes happen only while stepping through a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> (state_reg == S_STEP))
        else $error("stack write outside search");

endmodule
